### design/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/bvs_pkg.sv
// Shared types, constants and helpers for the bit vector similarity unit.
// No dependencies.
package bvs_pkg;

   typedef enum logic [1:0] {
      MODE_TANIMOTO = 2'd0,
      MODE_DICE     = 2'd1,
      MODE_HAMMING  = 2'd2
   } metric_type;

   localparam int SCORE_W   = 17;
   localparam int FIELD_W   = 12;
   localparam int DIV_STEPS = 17;   // quotient bits of I * 2^17 / D
   localparam int STEP_W    = 5;

   function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(v[k]);
      end
      return n;
   endfunction

endpackage

### design/bvs_if.sv
// Handshake interfaces for the byte pair stream and the result stream.
// Depends on nothing; used by the top level, front and back.
interface bvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_a;
   logic [7:0] byte_b;
   logic       last_byte;

   modport source (output valid, byte_a, byte_b, last_byte, input ready);
   modport sink   (input valid, byte_a, byte_b, last_byte, output ready);
endinterface

interface bvs_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] score;
   logic [11:0] common_bits;
   logic [11:0] either_bits;
   logic [11:0] differing_bits;
   logic        overflow;

   modport source (output valid, score, common_bits, either_bits, differing_bits,
                   overflow, input ready);
   modport sink   (input valid, score, common_bits, either_bits, differing_bits,
                   overflow, output ready);
endinterface

### design/bvs_front.sv
// Front end: takes byte pairs, keeps the AND/OR popcount totals and posts one
// job per vector pair to the queue. Depends on bvs_pkg and bvs_req_if.
module bvs_front #(
   parameter int MAX_BYTES = 256,
   parameter int CNT_W     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   bvs_req_if.sink                req,
   input  bvs_pkg::metric_type    metric_mode,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [2*CNT_W+2:0]     push_data
);

   localparam int PAIR_W = $clog2(MAX_BYTES + 1);

   logic [CNT_W-1:0]  and_ff, and_in;
   logic [CNT_W-1:0]  or_ff, or_in;
   logic [PAIR_W-1:0] pairs_ff, pairs_in;
   logic              ovf_ff, ovf_in;

   logic              counting;
   logic              accept;
   logic [CNT_W-1:0]  and_sum, or_sum;
   logic              ovf_sum;

   assign req.ready  = push_ready;
   assign accept     = req.valid && req.ready;
   assign counting   = pairs_ff < PAIR_W'(MAX_BYTES);

   assign and_sum = and_ff + (counting ?
                    CNT_W'(bvs_pkg::ones_in_byte(req.byte_a & req.byte_b)) : '0);
   assign or_sum  = or_ff + (counting ?
                    CNT_W'(bvs_pkg::ones_in_byte(req.byte_a | req.byte_b)) : '0);
   assign ovf_sum = ovf_ff | !counting;

   // job layout: mode, overflow, union, intersection
   assign push_valid = req.valid && req.last_byte;
   assign push_data  = {metric_mode, ovf_sum, or_sum, and_sum};

   always_comb begin
      and_in   = and_ff;
      or_in    = or_ff;
      pairs_in = pairs_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req.last_byte) begin
            and_in   = '0;
            or_in    = '0;
            pairs_in = '0;
            ovf_in   = 1'b0;
         end else begin
            and_in   = and_sum;
            or_in    = or_sum;
            ovf_in   = ovf_sum;
            if (counting) begin
               pairs_in = pairs_ff + PAIR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         and_ff   <= '0;
         or_ff    <= '0;
         pairs_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         and_ff   <= and_in;
         or_ff    <= or_in;
         pairs_ff <= pairs_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

### design/bvs_queue.sv
// Two-entry job queue between the front and back ends.
// No package dependencies.
module bvs_queue #(
   parameter int DATA_W = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/bvs_back.sv
// Back end: takes a job, runs a bit-serial restoring divide for the ratio
// modes and holds the result in the output register. Depends on bvs_pkg, bvs_rsp_if.
module bvs_back #(
   parameter int CNT_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  logic [2*CNT_W+2:0] job_data,
   bvs_rsp_if.source          rsp
);

   localparam int DEN_W = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_WRITE  = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [bvs_pkg::SCORE_W-1:0] quo_ff, quo_in;
   logic [bvs_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]           inter_ff, inter_in;
   logic [CNT_W-1:0]           uni_ff, uni_in;
   logic                       ovf_ff, ovf_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bvs_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [11:0]                common_ff, common_in;
   logic [11:0]                either_ff, either_in;
   logic [11:0]                differ_ff, differ_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   bvs_pkg::metric_type        job_mode;
   logic                       job_ovf;
   logic [CNT_W-1:0]           job_uni, job_inter;
   logic [DEN_W-1:0]           job_den;
   logic                       is_ratio;
   logic [DEN_W:0]             trial;
   logic                       out_free;

   assign job_inter = job_data[CNT_W-1:0];
   assign job_uni   = job_data[2*CNT_W-1:CNT_W];
   assign job_ovf   = job_data[2*CNT_W];
   assign job_mode  = bvs_pkg::metric_type'(job_data[2*CNT_W+2:2*CNT_W+1]);

   // Tanimoto as I*2^17 / 2U shares the Dice datapath
   assign job_den  = (job_mode == bvs_pkg::MODE_TANIMOTO) ? {job_uni, 1'b0}
                     : DEN_W'(job_inter) + DEN_W'(job_uni);
   assign is_ratio = (job_mode == bvs_pkg::MODE_TANIMOTO) ||
                     (job_mode == bvs_pkg::MODE_DICE);

   assign trial     = {rem_ff, 1'b0};
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign job_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      inter_in     = inter_ff;
      uni_in       = uni_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      score_in     = score_ff;
      common_in    = common_ff;
      either_in    = either_ff;
      differ_in    = differ_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               inter_in = job_inter;
               uni_in   = job_uni;
               ovf_in   = job_ovf;
               den_in   = job_den;
               rem_in   = DEN_W'(job_inter);
               step_in  = '0;
               if (is_ratio && (job_den != '0)) begin
                  quo_in   = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  // empty union, Hamming or unused mode
                  quo_in   = (job_mode == bvs_pkg::MODE_HAMMING) ?
                             bvs_pkg::SCORE_W'(job_uni - job_inter) : '0;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_DIVIDE: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[bvs_pkg::SCORE_W-2:0], 1'b1};
            end else begin
               rem_in = DEN_W'(trial);
               quo_in = {quo_ff[bvs_pkg::SCORE_W-2:0], 1'b0};
            end
            step_in = step_ff + bvs_pkg::STEP_W'(1);
            if (step_ff == bvs_pkg::STEP_W'(bvs_pkg::DIV_STEPS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               score_in     = quo_ff;
               common_in    = 12'(inter_ff);
               either_in    = 12'(uni_ff);
               differ_in    = 12'(uni_ff - inter_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      inter_ff   <= inter_in;
      uni_ff     <= uni_in;
      ovf_ff     <= ovf_in;
      score_ff   <= score_in;
      common_ff  <= common_in;
      either_ff  <= either_in;
      differ_ff  <= differ_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.score          = score_ff;
   assign rsp.common_bits    = common_ff;
   assign rsp.either_bits    = either_ff;
   assign rsp.differing_bits = differ_ff;
   assign rsp.overflow       = rsp_ovf_ff;

endmodule

### design/bit_vector_similarity_unit.sv
// Bit vector similarity unit: Tanimoto, Dice or Hamming over two fingerprints.
// Channels: req_port carries one byte pair per transfer (byte_a, byte_b,
// last_byte); rsp_port carries one result per vector pair (score,
// common_bits, either_bits, differing_bits, overflow).
// csr_wr_en/csr_wr_data write metric_mode (0 Tanimoto, 1 Dice, 2 Hamming).
// Throughput: the front end takes one byte pair every cycle while the job queue
// has room. Each ratio result takes the back end through idle, the one-bit-per-cycle
// divider and the write state; Hamming, an empty union or the unused mode skips the divider.
// A two-entry job queue lets the front run on while the back divides, so
// vector pairs of 19 or more bytes stream without stalls.
// After the last byte pair's transfer, the job passes through the queue, the back end's
// idle state, the divider (ratio modes only) and the write state into the result register.
// Reset (synchronous, active high) clears the totals, the queue, the result
// valid flag and sets metric_mode to Tanimoto.
// A stalled receiver holds the result register; the queue then fills and
// req_port.ready drops once two more vector jobs are waiting.
// Depends on bvs_pkg, bvs_if, bvs_front, bvs_queue, bvs_back, assert_macros.svh.
`include "assert_macros.svh"

module bit_vector_similarity_unit #(
   parameter int MAX_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   bvs_req_if.sink    req_port,
   bvs_rsp_if.source  rsp_port,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(8 * MAX_BYTES + 1);
   localparam int JOB_W = 2 * CNT_W + 3;

   bvs_pkg::metric_type metric_ff, metric_in;

   logic             push_valid, push_ready;
   logic [JOB_W-1:0] push_data;
   logic             job_valid, job_ready;
   logic [JOB_W-1:0] job_data;
   logic [11:0]      rsp_xor_calc;
   logic             last_xfer;

   assign metric_in = csr_wr_en ? bvs_pkg::metric_type'(csr_wr_data) : metric_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= bvs_pkg::MODE_TANIMOTO;
      end else begin
         metric_ff <= metric_in;
      end
   end

   bvs_front #(
      .MAX_BYTES (MAX_BYTES),
      .CNT_W     (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_port),
      .metric_mode (metric_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   bvs_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_data)
   );

   bvs_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .rsp       (rsp_port)
   );

   assign rsp_xor_calc = rsp_port.either_bits - rsp_port.common_bits;
   assign last_xfer    = req_port.valid && req_port.ready && req_port.last_byte;

   `ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_port.valid)
   `ASSERT_IMPLIES(a_xor_count, clock, reset, rsp_port.valid, rsp_port.differing_bits == rsp_xor_calc)
   `ASSERT_IMPLIES(a_score_range, clock, reset, rsp_port.valid, rsp_port.score <= 17'd65536)
   `ASSERT_IMPLIES(a_last_needs_room, clock, reset, last_xfer, push_ready)

endmodule

### tb/sv/tb_bit_vector_similarity_unit.sv
// Self-checking testbench for bit_vector_similarity_unit: byte pair streams in,
// similarity results checked against an in-bench score predictor.
// Depends on bvs_pkg, bvs_if and the RTL of the unit.
module tb_bit_vector_similarity_unit;

   localparam int          MAX_PAIRS    = 256;
   localparam int          SETTLE_TICKS = 40;
   localparam int          STALL_LIMIT  = 2000;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   typedef struct packed {
      logic [bvs_pkg::SCORE_W-1:0] score;
      logic [bvs_pkg::FIELD_W-1:0] common_bits;
      logic [bvs_pkg::FIELD_W-1:0] either_bits;
      logic [bvs_pkg::FIELD_W-1:0] differing_bits;
      logic                        overflow;
   } similarity_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   bvs_req_if req_port ();
   bvs_rsp_if rsp_port ();

   bit_vector_similarity_unit #(.MAX_BYTES(MAX_PAIRS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [1:0]     metric_now;
   int unsigned    common_total;
   int unsigned    either_total;
   int unsigned    pairs_total;
   bit             limit_hit;
   similarity_type expected_scores[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned errors;
   int unsigned stall_ticks;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      rsp_port.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready)) begin
         stall_ticks = 0;
      end else begin
         stall_ticks++;
         if (stall_ticks >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      similarity_type want;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (expected_scores.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual score %0d common %0d",
                     $time, rsp_port.score, rsp_port.common_bits);
         end else begin
            want = expected_scores.pop_front();
            check_field("score", want.score, rsp_port.score);
            check_field("common_bits", want.common_bits, rsp_port.common_bits);
            check_field("either_bits", want.either_bits, rsp_port.either_bits);
            check_field("differing_bits", want.differing_bits, rsp_port.differing_bits);
            check_field("overflow", want.overflow, rsp_port.overflow);
         end
      end
   end

   // fold one accepted pair into the totals; the last pair closes the vectors
   task automatic absorb_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
      similarity_type    res;
      longint unsigned   inter;
      longint unsigned   uni;
      longint unsigned   score;
      if (pairs_total < MAX_PAIRS) begin
         common_total += $countones(a & b);
         either_total += $countones(a | b);
         pairs_total++;
      end else begin
         limit_hit = 1'b1;
      end
      if (last) begin
         inter = common_total;
         uni   = either_total;
         score = 0;
         case (metric_now)
            bvs_pkg::MODE_TANIMOTO: begin
               if (uni != 0) score = (inter << 16) / uni;
            end
            bvs_pkg::MODE_DICE: begin
               if (inter + uni != 0) score = (inter << 17) / (inter + uni);
            end
            bvs_pkg::MODE_HAMMING: score = uni - inter;
            default: score = 0;
         endcase
         res.score          = bvs_pkg::SCORE_W'(score);
         res.common_bits    = bvs_pkg::FIELD_W'(inter);
         res.either_bits    = bvs_pkg::FIELD_W'(uni);
         res.differing_bits = bvs_pkg::FIELD_W'(uni - inter);
         res.overflow       = limit_hit;
         expected_scores.push_back(res);
         common_total = 0;
         either_total = 0;
         pairs_total  = 0;
         limit_hit    = 1'b0;
      end
   endtask

   // valid is left high after the transfer; the next call or a drain decides
   task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid     <= 1'b1;
      req_port.byte_a    <= a;
      req_port.byte_b    <= b;
      req_port.last_byte <= last;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      absorb_pair(a, b, last);
   endtask

   task automatic drain_scores();
      req_port.valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_metric(input logic [1:0] mode);
      drain_scores();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      metric_now  = mode;
   endtask

   task automatic test_score_extremes();
      write_metric(bvs_pkg::MODE_TANIMOTO);
      send_pair(8'h00, 8'h00, 1'b1);   // empty union
      send_pair(8'hFF, 8'hFF, 1'b1);   // full score
      send_pair(8'hFF, 8'h00, 1'b0);
      send_pair(8'h00, 8'hFF, 1'b1);   // no common bits
      send_pair(8'hAA, 8'h55, 1'b0);
      send_pair(8'hF0, 8'hFF, 1'b1);
      write_metric(bvs_pkg::MODE_DICE);
      send_pair(8'h00, 8'h00, 1'b1);
      send_pair(8'hFF, 8'hFF, 1'b1);
      send_pair(8'h0F, 8'hFF, 1'b1);
      send_pair(8'h01, 8'h80, 1'b0);
      send_pair(8'h81, 8'h81, 1'b1);
   endtask

   task automatic test_hamming_and_unused_mode();
      write_metric(bvs_pkg::MODE_HAMMING);
      send_pair(8'hFF, 8'h00, 1'b1);
      send_pair(8'hFF, 8'hFF, 1'b1);
      send_pair(8'h00, 8'h00, 1'b1);
      send_pair(8'h3C, 8'hC3, 1'b1);
      write_metric(MODE_UNUSED);
      send_pair(8'hA5, 8'h5A, 1'b0);
      send_pair(8'hFF, 8'h0F, 1'b1);
   endtask

   // exactly at the pair limit, then past it with the closing pair beyond it
   task automatic test_pair_limit();
      int unsigned extra;
      write_metric(bvs_pkg::MODE_HAMMING);
      for (int i = 0; i < MAX_PAIRS; i++) begin
         send_pair(8'($urandom), 8'($urandom), i == MAX_PAIRS - 1);
      end
      write_metric(bvs_pkg::MODE_DICE);
      extra = $urandom_range(1, 6);
      for (int i = 0; i < MAX_PAIRS + extra; i++) begin
         send_pair(8'hFF, 8'($urandom), i == MAX_PAIRS + extra - 1);
      end
   endtask

   task automatic test_random_stream(input int unsigned n_items, input bit hold_midway);
      int unsigned sent;
      int unsigned next_mode_at;
      int unsigned len;
      logic [7:0]  a;
      logic [7:0]  b;
      bit          held;
      sent = 0;
      held = 0;
      next_mode_at = 0;
      while (sent < n_items) begin
         if (sent >= next_mode_at) begin
            write_metric(2'($urandom_range(3)));
            next_mode_at = sent + $urandom_range(60, 160);
         end
         if (hold_midway && !held && sent >= n_items / 2) begin
            drain_scores();
            held = 1;
         end
         case ($urandom_range(19))
            0:       len = $urandom_range(200, 300);
            1, 2, 3: len = $urandom_range(25, 64);
            default: len = $urandom_range(1, 24);
         endcase
         for (int i = 0; i < len; i++) begin
            a = 8'($urandom);
            case ($urandom_range(9))
               0:       b = a;
               1:       b = ~a;
               2:       begin a = 8'h00; b = 8'($urandom); end
               3:       begin a = 8'hFF; b = 8'($urandom); end
               default: b = 8'($urandom);
            endcase
            send_pair(a, b, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= bvs_pkg::MODE_TANIMOTO;
      req_port.valid     <= 1'b0;
      req_port.byte_a    <= 8'h00;
      req_port.byte_b    <= 8'h00;
      req_port.last_byte <= 1'b0;
      metric_now   = bvs_pkg::MODE_TANIMOTO;
      common_total = 0;
      either_total = 0;
      pairs_total  = 0;
      limit_hit    = 1'b0;
      errors       = 0;
      stall_ticks  = 0;
      send_idle_pct = 15;
      recv_idle_pct = 71;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_score_extremes();
      test_hamming_and_unused_mode();
      test_pair_limit();
      test_random_stream(400, 1'b1);
      send_idle_pct = 71;
      recv_idle_pct = 15;
      test_random_stream(400, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(400, 1'b0);
      drain_scores();

      if (errors == 0 && expected_scores.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
